>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication or plain property under clock, disabled during reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> design/lbp_pkg.sv
// ---------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the LSB-first bit packer.
// ---------------------------------------------------------------------------
package lbp_pkg;

  // Input op codes
  typedef enum logic [1:0] {
    OP_RAW    = 2'd0,
    OP_RAW64  = 2'd1,
    OP_VARINT = 2'd2,
    OP_FINISH = 2'd3
  } lbp_op_e;

  // Kind of a queued piece of work
  typedef enum logic {
    PC_WRITE  = 1'b0,
    PC_FINISH = 1'b1
  } piece_kind_e;

  // Capacity saturation limit in bytes
  localparam int unsigned MaxBytes = 4096;
  localparam int unsigned CapW     = 13;
  localparam int unsigned CurW     = 16;
  localparam int unsigned IdxW     = 13;
  localparam int unsigned NbW      = 6;
  localparam int unsigned PieceW   = 32;

  // Depth of the piece queue (power of two)
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);

  // One checked write (1..32 bits) or a finish request
  typedef struct packed {
    piece_kind_e         kind;
    logic [NbW-1:0]      nbits;
    logic [PieceW-1:0]   bits;
  } piece_t;

  // Queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> design/lsb_first_bit_packer_varint.sv
// ---------------------------------------------------------------------------
// lsb_first_bit_packer_varint
// LSB-first bit packer with raw, 64-bit, varint and finish ops.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one op word: op_i, value_i,
//   width_i. Output channel (out_valid_o / out_stall_i) returns one word per
//   completed byte, plus one word with last_o set for each finish op. cfg_we_i
//   writes capacity_bytes (cfg_wdata_i); user must keep block idle, unchecked.
// Timing:
//   An op word is registered by the front splitter, which pushes one piece
//   (raw group, 32-bit half, varint group, continuation bit or finish) per
//   cycle into a 4-entry queue while the queue is not full. The back packer
//   takes one piece per cycle while idle (a finish also waits for a free
//   output register) and emits completed bytes one per cycle while the output
//   is not stalled. A new op word is accepted only after the last piece of
//   the previous one is pushed.
// Reset:
//   Cursor, pending byte and overflow flag clear; capacity returns to 4096.
// Stall:
//   The output register holds its word while out_stall_i is high; the queue
//   then fills and in_stall_o stays high while the splitter cannot push.
// ---------------------------------------------------------------------------
module lsb_first_bit_packer_varint (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [12:0]  cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   op_i,
  input  logic [63:0]  value_i,
  input  logic [5:0]   width_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   data_byte_o,
  output logic [11:0]  byte_index_o,
  output logic         byte_valid_o,
  output logic         last_o,
  output logic         overflow_o,
  output logic [15:0]  bit_count_o
);

  lbp_pkg::qstat_t  qstat;
  lbp_pkg::piece_t  push_piece;
  lbp_pkg::piece_t  head_piece;
  logic             push;
  logic             pop;

  // Front: op splitter
  lbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .width_i    (width_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .piece_o    (push_piece)
  );

  // Piece queue
  lbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .piece_i (push_piece),
    .pop_i   (pop),
    .piece_o (head_piece),
    .qstat_o (qstat)
  );

  // Back: packer and byte emitter
  lbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .qstat_i      (qstat),
    .piece_i      (head_piece),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .overflow_o   (overflow_o),
    .bit_count_o  (bit_count_o)
  );

endmodule

>>> design/lbp_front.sv
// ---------------------------------------------------------------------------
// lbp_front
// Accepts input words and splits each op into checked pieces for the queue.
// ---------------------------------------------------------------------------
module lbp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [63:0]          value_i,
  input  logic [5:0]           width_i,
  input  lbp_pkg::qstat_t      qstat_i,
  output logic                 push_o,
  output lbp_pkg::piece_t      piece_o
);

  logic              busy_q, busy_d;
  logic              ph_q, ph_d;
  lbp_pkg::lbp_op_e  op_q;
  logic [63:0]       val_q, val_d;
  logic [5:0]        wid_q;
  logic              accept;
  logic              need_push;
  logic              last_piece;
  logic              fin;
  logic [31:0]       raw_mask;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  // Mask for a raw write of wid_q bits (0..32)
  assign raw_mask = 32'hFFFF_FFFF >> (6'd32 - wid_q);

  // Piece generation for the op being split
  always_comb begin
    piece_o.kind  = lbp_pkg::PC_WRITE;
    piece_o.nbits = '0;
    piece_o.bits  = '0;
    need_push     = 1'b1;
    last_piece    = 1'b1;
    unique case (op_q)
      lbp_pkg::OP_RAW: begin
        piece_o.nbits = wid_q;
        piece_o.bits  = val_q[31:0] & raw_mask;
        need_push     = (wid_q != 6'd0);
      end
      lbp_pkg::OP_RAW64: begin
        piece_o.nbits = 6'd32;
        piece_o.bits  = ph_q ? val_q[63:32] : val_q[31:0];
        last_piece    = ph_q;
      end
      lbp_pkg::OP_VARINT: begin
        if (!ph_q) begin
          piece_o.nbits = 6'd7;
          piece_o.bits  = {25'd0, val_q[6:0]};
          last_piece    = 1'b0;
        end else begin
          // continuation bit; val_q already holds the shifted remainder
          piece_o.nbits = 6'd1;
          piece_o.bits  = {31'd0, (val_q != 64'd0)};
          last_piece    = (val_q == 64'd0);
        end
      end
      lbp_pkg::OP_FINISH: begin
        piece_o.kind = lbp_pkg::PC_FINISH;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  assign push_o = busy_q && need_push && !qstat_i.full;
  assign fin    = busy_q && (need_push ? (!qstat_i.full && last_piece) : 1'b1);

  // Next-state of the splitter
  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    val_d  = val_q;
    if (accept) begin
      busy_d = 1'b1;
      ph_d   = 1'b0;
      val_d  = value_i;
    end else begin
      if (fin) begin
        busy_d = 1'b0;
      end
      if (push_o) begin
        ph_d = ~ph_q;
        if (op_q == lbp_pkg::OP_VARINT && !ph_q) begin
          val_d = val_q >> 7;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (accept) begin
      op_q  <= lbp_pkg::lbp_op_e'(op_i);
      wid_q <= (width_i > 6'd32) ? 6'd32 : width_i;
    end
  end

endmodule

>>> design/lbp_queue.sv
// ---------------------------------------------------------------------------
// lbp_queue
// Short FIFO of pieces between the front splitter and the back packer.
// ---------------------------------------------------------------------------
module lbp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lbp_pkg::piece_t  piece_i,
  input  logic             pop_i,
  output lbp_pkg::piece_t  piece_o,
  output lbp_pkg::qstat_t  qstat_o
);

  lbp_pkg::piece_t               mem_q [lbp_pkg::QDepth];
  logic [lbp_pkg::QAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [lbp_pkg::QAw:0]         cnt_q;
  logic                          do_push, do_pop;

  assign qstat_o.full  = (cnt_q == (lbp_pkg::QAw+1)'(lbp_pkg::QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign piece_o       = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= piece_i;
    end
  end

endmodule

>>> design/lbp_back.sv
// ---------------------------------------------------------------------------
// lbp_back
// Checks each piece against capacity, packs it and emits completed bytes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lbp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lbp_pkg::CapW-1:0]  cfg_wdata_i,
  input  lbp_pkg::qstat_t           qstat_i,
  input  lbp_pkg::piece_t           piece_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                data_byte_o,
  output logic [11:0]               byte_index_o,
  output logic                      byte_valid_o,
  output logic                      last_o,
  output logic                      overflow_o,
  output logic [15:0]               bit_count_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                      st_q, st_d;
  logic [lbp_pkg::CurW-1:0]  cur_q, cur_d;
  logic [7:0]                pend_q, pend_d;
  logic                      ovf_q, ovf_d;
  logic [lbp_pkg::CapW-1:0]  cap_q;
  logic [39:0]               acc_q, acc_d;
  logic [2:0]                left_q, left_d;
  logic [lbp_pkg::IdxW-1:0]  idx_q, idx_d;

  logic                      ov_q, ov_d;
  logic [7:0]                data_q, data_d;
  logic [11:0]               bidx_q, bidx_d;
  logic                      bv_q, bv_d;
  logic                      last_q, last_d;
  logic                      oflag_q, oflag_d;
  logic [15:0]               bc_q, bc_d;

  logic                      out_free;
  logic                      load;
  logic [2:0]                cur_lo;
  logic [39:0]               acc_new;
  logic [lbp_pkg::CurW:0]    sum;
  logic [lbp_pkg::CapW-1:0]  cap_sat;
  logic [lbp_pkg::CurW-1:0]  cap_bits;
  logic                      fits;
  logic [5:0]                total;
  logic [2:0]                nbytes;
  logic [lbp_pkg::IdxW-1:0]  idx_inc;

  assign out_free = !ov_q || !out_stall_i;
  assign cur_lo   = cur_q[2:0];
  assign idx_inc  = idx_q + 1'b1;

  // Merge new bits above the pending ones
  assign acc_new  = ({8'd0, piece_i.bits} << cur_lo) | {32'd0, pend_q};

  // Capacity check: cursor plus piece width against saturated capacity
  assign cap_sat  = (cap_q > lbp_pkg::CapW'(lbp_pkg::MaxBytes))
                    ? lbp_pkg::CapW'(lbp_pkg::MaxBytes) : cap_q;
  assign cap_bits = {cap_sat, 3'b000};
  assign sum      = {1'b0, cur_q} + (lbp_pkg::CurW+1)'(piece_i.nbits);
  assign fits     = (sum <= {1'b0, cap_bits});
  assign total    = {3'd0, cur_lo} + piece_i.nbits;
  assign nbytes   = total[5:3];

  // Sequencer
  always_comb begin
    st_d    = st_q;
    cur_d   = cur_q;
    pend_d  = pend_q;
    ovf_d   = ovf_q;
    acc_d   = acc_q;
    left_d  = left_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    data_d  = data_q;
    bidx_d  = bidx_q;
    bv_d    = bv_q;
    last_d  = last_q;
    oflag_d = oflag_q;
    bc_d    = bc_q;
    unique case (st_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          if (piece_i.kind == lbp_pkg::PC_FINISH) begin
            if (out_free) begin
              // flush the partial byte, report the count, start over
              pop_o   = 1'b1;
              load    = 1'b1;
              bv_d    = (cur_lo != 3'd0);
              data_d  = bv_d ? pend_q : 8'd0;
              bidx_d  = bv_d ? cur_q[14:3] : 12'd0;
              last_d  = 1'b1;
              oflag_d = ovf_q;
              bc_d    = cur_q;
              cur_d   = '0;
              pend_d  = '0;
              ovf_d   = 1'b0;
            end
          end else begin
            pop_o = 1'b1;
            if (!fits) begin
              ovf_d = 1'b1;
            end else begin
              cur_d = sum[lbp_pkg::CurW-1:0];
              if (nbytes == 3'd0) begin
                pend_d = acc_new[7:0];
              end else begin
                st_d   = ST_EMIT;
                acc_d  = acc_new;
                left_d = nbytes;
                idx_d  = cur_q[lbp_pkg::CurW-1:3];
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          // one completed byte per cycle while the output register is free
          load    = 1'b1;
          data_d  = acc_q[7:0];
          bidx_d  = idx_q[11:0];
          bv_d    = 1'b1;
          last_d  = 1'b0;
          oflag_d = ovf_q;
          bc_d    = {idx_inc, 3'b000};
          acc_d   = acc_q >> 8;
          idx_d   = idx_inc;
          left_d  = left_q - 1'b1;
          if (left_q == 3'd1) begin
            pend_d = acc_q[15:8];
            st_d   = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    if (load) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  // Control and packing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cur_q  <= '0;
      pend_q <= '0;
      ovf_q  <= 1'b0;
      cap_q  <= lbp_pkg::CapW'(4096);
      left_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cur_q  <= cur_d;
      pend_q <= pend_d;
      ovf_q  <= ovf_d;
      left_q <= left_d;
      ov_q   <= ov_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    idx_q   <= idx_d;
    data_q  <= data_d;
    bidx_q  <= bidx_d;
    bv_q    <= bv_d;
    last_q  <= last_d;
    oflag_q <= oflag_d;
    bc_q    <= bc_d;
  end

  assign out_valid_o  = ov_q;
  assign data_byte_o  = data_q;
  assign byte_index_o = bidx_q;
  assign byte_valid_o = bv_q;
  assign last_o       = last_q;
  assign overflow_o   = oflag_q;
  assign bit_count_o  = bc_q;

  // Checks; the pending byte is only current while idle (emit keeps it in acc)
  `ASSERT_PROP(a_emit_has_bytes, clk_i, rst_ni, (st_q == ST_EMIT) |-> (left_q != 3'd0),
               "emit state with no bytes left")
  `ASSERT_NEVER(a_pend_clean, clk_i, rst_ni,
                (st_q == ST_IDLE) && ((pend_q >> cur_lo) != 8'd0),
                "pending byte has bits above the cursor")
  `ASSERT_PROP(a_finish_partial, clk_i, rst_ni,
               (ov_q && last_q && bv_q) |-> (bc_q[2:0] != 3'd0),
               "finish reported a partial byte on a byte boundary")
  `ASSERT_NEVER(a_finish_in_emit, clk_i, rst_ni, load && last_d && (st_q == ST_EMIT),
                "finish result loaded while bytes are still pending")

endmodule

>>> bench/tb_lsb_first_bit_packer_varint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_packer_varint
// Self-checking bench for the LSB-first bit packer. It sends raw, 64-bit,
// varint and finish words across a range of capacity settings and idle
// patterns. Every output word is checked against a packer model kept here.
// ----------------------------------------------------------------------------

// One output word as the block presents it
typedef struct {
  logic [7:0]  data;
  logic [11:0] idx;
  logic        vld;
  logic        last;
  logic        ovf;
  logic [15:0] bits;
} out_word_t;

// Bit packer model plus the queue of words still owed by the block
class bit_stream_board;
  int unsigned cap_bytes;
  int unsigned cursor;
  logic [7:0]  pend;
  logic        ovf;
  out_word_t   bytes_due[$];
  int unsigned faults;

  function new();
    cap_bytes = lbp_pkg::MaxBytes;
    cursor    = 0;
    pend      = '0;
    ovf       = 1'b0;
    faults    = 0;
  endfunction

  function void set_capacity(logic [12:0] cap);
    cap_bytes = 32'(cap);
  endfunction

  // Owe one word; the sticky flag is taken as it stands right now
  function void push_word(logic [7:0] data, int unsigned idx, logic vld, logic last);
    out_word_t w;
    w.data = data;
    w.idx  = idx[11:0];
    w.vld  = vld;
    w.last = last;
    w.ovf  = ovf;
    w.bits = cursor[15:0];
    bytes_due.push_back(w);
  endfunction

  // One checked write of n bits, LSB first; all or nothing
  function void pack_bits(logic [31:0] v, int unsigned n);
    int unsigned lim;
    int unsigned i;
    lim = ((cap_bytes > lbp_pkg::MaxBytes) ? lbp_pkg::MaxBytes : cap_bytes) * 8;
    if (n > 32) n = 32;
    if (n == 0) return;
    if (cursor + n > lim) begin
      ovf = 1'b1;
      return;
    end
    for (i = 0; i < n; i++) begin
      pend[cursor[2:0]] = v[i];
      cursor++;
      if (cursor % 8 == 0) begin
        push_word(pend, cursor / 8 - 1, 1'b1, 1'b0);
        pend = '0;
      end
    end
  endfunction

  // Work out the words caused by one accepted input word
  function void note_word(lbp_pkg::lbp_op_e op, logic [63:0] value, logic [5:0] width);
    logic [63:0] rest;
    logic [6:0]  grp;
    case (op)
      lbp_pkg::OP_RAW: pack_bits(value[31:0], 32'(width));
      lbp_pkg::OP_RAW64: begin
        pack_bits(value[31:0], 32);
        pack_bits(value[63:32], 32);
      end
      lbp_pkg::OP_VARINT: begin
        // each group and each continuation bit is checked on its own
        rest = value;
        do begin
          grp  = rest[6:0];
          rest = rest >> 7;
          pack_bits({25'd0, grp}, 7);
          pack_bits({31'd0, rest != 0}, 1);
        end while (rest != 0);
      end
      lbp_pkg::OP_FINISH: begin
        if (cursor % 8 != 0) push_word(pend, cursor / 8, 1'b1, 1'b1);
        else push_word(8'd0, 0, 1'b0, 1'b1);
        cursor = 0;
        pend   = '0;
        ovf    = 1'b0;
      end
    endcase
  endfunction

  task report(string msg);
    if (faults < 50) $display("[%0t] mismatch: %s", $time, msg);
    faults++;
  endtask

  task check_word(logic [7:0] data, logic [11:0] idx, logic vld, logic last,
                  logic ovf_o, logic [15:0] bits);
    out_word_t want;
    if (bytes_due.size() == 0) begin
      report($sformatf("word with nothing due: data %02h index %0d last %b",
                       data, idx, last));
      return;
    end
    want = bytes_due.pop_front();
    if (data !== want.data)
      report($sformatf("data_byte %02h, want %02h (index %0d)", data, want.data, want.idx));
    if (idx !== want.idx)
      report($sformatf("byte_index %0d, want %0d", idx, want.idx));
    if (vld !== want.vld)
      report($sformatf("byte_valid %b, want %b (index %0d)", vld, want.vld, want.idx));
    if (last !== want.last)
      report($sformatf("last %b, want %b (index %0d)", last, want.last, want.idx));
    if (ovf_o !== want.ovf)
      report($sformatf("overflow %b, want %b (index %0d)", ovf_o, want.ovf, want.idx));
    if (bits !== want.bits)
      report($sformatf("bit_count %0d, want %0d (index %0d)", bits, want.bits, want.idx));
  endtask
endclass

module tb_lsb_first_bit_packer_varint;

  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 55;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [12:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [63:0] value_i;
  logic [5:0]  width_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  data_byte_o;
  logic [11:0] byte_index_o;
  logic        byte_valid_o;
  logic        last_o;
  logic        overflow_o;
  logic [15:0] bit_count_o;

  int unsigned tx_pct;
  int unsigned rx_pct;
  int unsigned hold_cycles;
  int unsigned quiet_cycles;
  bit_stream_board board;

  lsb_first_bit_packer_varint i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .width_i      (width_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .overflow_o   (overflow_o),
    .bit_count_o  (bit_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Output side: long hold-off when asked, else random stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_pct);
      end
    end
  end

  // Check each word taken from the output
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_word(data_byte_o, byte_index_o, byte_valid_o, last_o,
                       overflow_o, bit_count_o);
  end

  // Watchdog: too long with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("[%0t] no progress for %0d cycles", $time, QuietLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one word, with random gaps in front; valid stays up after accept
  task automatic send_word(lbp_pkg::lbp_op_e op, logic [63:0] value, logic [5:0] width);
    if ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_pct);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    width_i    <= width;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word(op, value, width);
  endtask

  // Drop valid and wait until every owed word is back, then some slack
  task automatic quiesce(int unsigned extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.bytes_due.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [12:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_capacity(cap);
  endtask

  task automatic send_random(int unsigned fin_pct);
    int unsigned      r;
    logic [63:0]      value;
    logic [5:0]       width;
    lbp_pkg::lbp_op_e op;
    value = {$urandom, $urandom};
    width = 6'($urandom_range(1, 32));
    if ($urandom_range(0, 99) < fin_pct) begin
      op = lbp_pkg::OP_FINISH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        op = lbp_pkg::OP_RAW;
      end else if (r < 62) begin
        op = lbp_pkg::OP_RAW64;
      end else begin
        // spread varint lengths from one group to ten
        op    = lbp_pkg::OP_VARINT;
        value = value >> $urandom_range(0, 63);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 6) width = 6'd0;
    else if (r < 16) width = 6'($urandom_range(33, 63));
    send_word(op, value, width);
  endtask

  task automatic run_directed();
    // raw edges: zero width, one bit, full width, oversize width
    send_word(lbp_pkg::OP_RAW, '1, 6'd0);
    send_word(lbp_pkg::OP_RAW, 64'd1, 6'd1);
    send_word(lbp_pkg::OP_RAW, '1, 6'd32);
    send_word(lbp_pkg::OP_RAW, 64'hA5A5_5A5A_0F0F_F0F0, 6'd63);
    send_word(lbp_pkg::OP_RAW, 64'h55, 6'd6);
    // finish with a partial byte, then with none
    send_word(lbp_pkg::OP_FINISH, '0, 6'd0);
    send_word(lbp_pkg::OP_FINISH, '1, 6'd63);
    send_word(lbp_pkg::OP_RAW64, '1, 6'd0);
    send_word(lbp_pkg::OP_RAW64, '0, 6'd0);
    // varint: zero, longest, one group, just past one group
    send_word(lbp_pkg::OP_VARINT, '0, 6'd0);
    send_word(lbp_pkg::OP_VARINT, '1, 6'd0);
    send_word(lbp_pkg::OP_VARINT, 64'd127, 6'd0);
    send_word(lbp_pkg::OP_VARINT, 64'd128, 6'd0);
    send_word(lbp_pkg::OP_FINISH, '0, 6'd0);
    // zero capacity: only empty writes pass
    quiesce(DrainCycles);
    write_capacity(13'd0);
    send_word(lbp_pkg::OP_RAW, '1, 6'd0);
    send_word(lbp_pkg::OP_RAW, 64'd1, 6'd1);
    send_word(lbp_pkg::OP_VARINT, 64'd5, 6'd0);
    send_word(lbp_pkg::OP_FINISH, '0, 6'd0);
    // one byte: varint overflows partway, the 64-bit write after it overflows too
    quiesce(DrainCycles);
    write_capacity(13'd1);
    send_word(lbp_pkg::OP_VARINT, 64'd300, 6'd0);
    send_word(lbp_pkg::OP_RAW64, 64'h0123_4567_89AB_CDEF, 6'd0);
    send_word(lbp_pkg::OP_FINISH, '0, 6'd0);
    // capacity above the limit saturates
    quiesce(DrainCycles);
    write_capacity(13'd8191);
    send_word(lbp_pkg::OP_RAW, 64'd5, 6'd3);
    send_word(lbp_pkg::OP_FINISH, '0, 6'd0);
  endtask

  initial begin
    logic [12:0] caps [8];
    int unsigned fin_pct;
    int unsigned p;
    int unsigned k;
    caps = '{13'd5, 13'd13, 13'd2, 13'd300, 13'd4096, 13'd1, 13'd8191, 13'd0};
    board        = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    op_i         = lbp_pkg::OP_RAW;
    value_i      = '0;
    width_i      = '0;
    out_stall_i  = 1'b0;
    tx_pct       = 0;
    rx_pct       = 0;
    hold_cycles  = 0;
    quiet_cycles = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // random phases: one capacity and one idle pattern each
    for (p = 0; p < 8; p++) begin
      quiesce(DrainCycles);
      write_capacity(caps[p]);
      case (p % 4)
        0: begin
          tx_pct = 0;
          rx_pct = 0;
        end
        1: begin
          tx_pct = 65;
          rx_pct = 0;
        end
        2: begin
          tx_pct = 0;
          rx_pct = 65;
        end
        default: begin
          tx_pct = 38;
          rx_pct = 38;
        end
      endcase
      // long messages where the capacity allows them
      fin_pct = (caps[p] >= 300) ? 3 : 14;
      // output held off while input keeps coming: queue fills, input stalls
      if (p == 4) hold_cycles = HoldCycles;
      for (k = 0; k < PhaseItems; k++) begin
        if (p == 2 && k == PhaseItems / 2) quiesce(0);
        send_random(fin_pct);
      end
    end

    quiesce(DrainCycles);
    if (board.bytes_due.size() != 0)
      board.report($sformatf("%0d words never came out", board.bytes_due.size()));
    if (board.faults == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/lbp_pkg.sv
design/lbp_front.sv
design/lbp_queue.sv
design/lbp_back.sv
design/lsb_first_bit_packer_varint.sv
bench/tb_lsb_first_bit_packer_varint.sv
